// ===== hdl/veac_pkg.sv =====
// ----------------------------------------------------------------------------
// veac_pkg
// shared types, constants and helpers of the voronoi edge classifier
// ----------------------------------------------------------------------------
package veac_pkg;

   localparam int COORD_WIDTH          = 32;
   localparam int FRAC_BITS            = 16;
   localparam int RSQ_WIDTH            = 63;
   localparam int CSR_INDEX_WIDTH      = 3;
   localparam int CSR_DATA_WIDTH       = RSQ_WIDTH;
   localparam int DEFAULT_NUM_CIRCLES  = 3;
   localparam int MAX_CIRCLES          = 3;

   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int VAL_W  = (2 * COORD_WIDTH + 4 > RSQ_WIDTH + 2) ?
                           2 * COORD_WIDTH + 4 : RSQ_WIDTH + 2;

   localparam int MUL_CHUNK  = 23;
   localparam int MUL_LAT    = 5;
   localparam int CIRCLE_LAT = 4 + MUL_LAT + 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int OQ_DEPTH    = 16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_OWN_X = 3'd0,
      REG_OWN_Y = 3'd1,
      REG_OLD_X = 3'd2,
      REG_OLD_Y = 3'd3,
      REG_NEW_X = 3'd4,
      REG_NEW_Y = 3'd5,
      REG_RSQ   = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_SEG  = 2'd0,
      KIND_RAY  = 2'd1,
      KIND_FULL = 2'd2
   } edge_kind_type;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]      diff_type;
   typedef logic signed [PROD_W-1:0]      prod_type;
   typedef logic signed [VAL_W-1:0]       val_type;
   typedef logic signed [2*VAL_W:0]       wprod_type;
   typedef logic signed [2*VAL_W+1:0]     disc_type;
   typedef logic [RSQ_WIDTH-1:0]          rsq_type;

   typedef struct packed {
      coord_type     lx;
      coord_type     ly;
      coord_type     rx;
      coord_type     ry;
      coord_type     a;
      coord_type     b;
      coord_type     c;
      coord_type     sx;
      coord_type     sy;
      diff_type      dx;
      diff_type      dy;
      logic          hl;
      logic          hr;
      logic          sel_l;
      logic          lself;
      logic          rself;
      edge_kind_type kind;
   } item_type;

   localparam int ITEM_W = $bits(item_type);

   typedef struct packed {
      coord_type own_x;
      coord_type own_y;
      coord_type old_x;
      coord_type old_y;
      coord_type new_x;
      coord_type new_y;
      rsq_type   rsq;
      logic      disc_on;
   } cfg_type;

   typedef struct packed {
      logic hit;
      logic l_in;
      logic r_in;
   } hit_type;

   typedef struct packed {
      logic inner_own;
      logic inner_old;
      logic inner_new;
      logic outer_edge;
      logic left_enclosing;
      logic right_enclosing;
   } result_type;

   localparam int RESULT_W = $bits(result_type);

   function automatic diff_type ext_d(coord_type v);
      return {v[COORD_WIDTH-1], v};
   endfunction

endpackage

// ===== hdl/veac_req_if.sv =====
// ----------------------------------------------------------------------------
// veac_req_if
// edge item channel: valid, ready and the edge fields
// ----------------------------------------------------------------------------
interface veac_req_if import veac_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type left_x;
   coord_type left_y;
   coord_type right_x;
   coord_type right_y;
   logic      has_left;
   logic      has_right;
   coord_type coef_a;
   coord_type coef_b;
   coord_type coef_c;
   logic      left_is_self;
   logic      right_is_self;

   modport source (
      output valid, left_x, left_y, right_x, right_y, has_left, has_right,
             coef_a, coef_b, coef_c, left_is_self, right_is_self,
      input  ready
   );

   modport sink (
      input  valid, left_x, left_y, right_x, right_y, has_left, has_right,
             coef_a, coef_b, coef_c, left_is_self, right_is_self,
      output ready
   );
endinterface

// ===== hdl/veac_rsp_if.sv =====
// ----------------------------------------------------------------------------
// veac_rsp_if
// result item channel: valid, ready and the classification flags
// ----------------------------------------------------------------------------
interface veac_rsp_if;
   logic valid;
   logic ready;
   logic inner_own;
   logic inner_old;
   logic inner_new;
   logic outer_edge;
   logic left_enclosing;
   logic right_enclosing;

   modport source (
      output valid, inner_own, inner_old, inner_new, outer_edge,
             left_enclosing, right_enclosing,
      input  ready
   );

   modport sink (
      input  valid, inner_own, inner_old, inner_new, outer_edge,
             left_enclosing, right_enclosing,
      output ready
   );
endinterface

// ===== hdl/veac_fifo.sv =====
// ----------------------------------------------------------------------------
// veac_fifo
// small show-ahead queue with valid/ready on both sides
// ----------------------------------------------------------------------------
module veac_fifo #(
   parameter int W     = 1,
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data
);
   localparam int AW = $clog2(DEPTH);

   logic [W-1:0]  mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, wp_in;
   logic [AW-1:0] rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          push, pop;

   assign in_ready  = cnt_ff != (AW+1)'(DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_data  = mem_ff[rp_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= in_data;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(DEPTH))
      else $error("queue count beyond depth");
endmodule

// ===== hdl/veac_front.sv =====
// ----------------------------------------------------------------------------
// veac_front
// accepts edge items and sorts them into segment, ray or full line
// ----------------------------------------------------------------------------
module veac_front import veac_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   veac_req_if.sink req,
   output item_type item,
   output logic     item_valid,
   input  logic     item_ready
);
   item_type fe_item_ff, fe_item_in;
   logic     fe_valid_ff;
   logic     accept;
   logic     flip;

   assign req.ready  = !fe_valid_ff || item_ready;
   assign accept     = req.valid && req.ready;
   assign item       = fe_item_ff;
   assign item_valid = fe_valid_ff;

   always_comb begin
      fe_item_in       = '0;
      fe_item_in.lx    = req.left_x;
      fe_item_in.ly    = req.left_y;
      fe_item_in.rx    = req.right_x;
      fe_item_in.ry    = req.right_y;
      fe_item_in.a     = req.coef_a;
      fe_item_in.b     = req.coef_b;
      fe_item_in.c     = req.coef_c;
      fe_item_in.hl    = req.has_left;
      fe_item_in.hr    = req.has_right;
      fe_item_in.lself = req.left_is_self;
      fe_item_in.rself = req.right_is_self;
      fe_item_in.sel_l = req.has_left;
      fe_item_in.sx    = req.has_left ? req.left_x : req.right_x;
      fe_item_in.sy    = req.has_left ? req.left_y : req.right_y;
      // ray direction points to +x from a left end, to -x from a right end
      flip = req.has_left ? req.coef_b[COORD_WIDTH-1] : !req.coef_b[COORD_WIDTH-1];
      if (req.has_left && req.has_right) begin
         fe_item_in.kind = KIND_SEG;
         fe_item_in.dx   = ext_d(req.right_x) - ext_d(req.left_x);
         fe_item_in.dy   = ext_d(req.right_y) - ext_d(req.left_y);
      end else if (req.has_left || req.has_right) begin
         fe_item_in.kind = KIND_RAY;
         fe_item_in.dx   = flip ? -ext_d(req.coef_b) : ext_d(req.coef_b);
         fe_item_in.dy   = flip ? ext_d(req.coef_a) : -ext_d(req.coef_a);
      end else begin
         fe_item_in.kind = KIND_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fe_valid_ff <= 1'b0;
      end else if (accept) begin
         fe_valid_ff <= 1'b1;
      end else if (item_ready) begin
         fe_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fe_item_ff <= fe_item_in;
      end
   end
endmodule

// ===== hdl/veac_wmul.sv =====
// ----------------------------------------------------------------------------
// veac_wmul
// pipelined wide signed multiplier built from narrow partial products
// ----------------------------------------------------------------------------
module veac_wmul import veac_pkg::*; #(
   parameter int W = VAL_W
) (
   input  logic                clock,
   input  logic signed [W-1:0] a_in,
   input  logic signed [W-1:0] b_in,
   output logic signed [2*W:0] p_out
);
   localparam int C   = MUL_CHUNK;
   localparam int NCH = (W + C - 1) / C;
   localparam int MW  = NCH * C;
   localparam int PW  = 2 * MW;

   logic [W-1:0]      mag_a, mag_b;
   logic [MW-1:0]     ma_ff, mb_ff;
   logic              n1_ff, n2_ff, n3_ff, n4_ff;
   logic [2*C-1:0]    pp_ff [NCH][NCH];
   logic [PW-1:0]     row_c [NCH];
   logic [PW-1:0]     row_ff [NCH];
   logic [PW-1:0]     tot_c, tot_ff;
   logic signed [PW:0] t_c, r_c;
   logic signed [2*W:0] p_ff;

   always_comb begin
      mag_a = a_in[W-1] ? -a_in : a_in;
      mag_b = b_in[W-1] ? -b_in : b_in;
   end

   always_ff @(posedge clock) begin
      ma_ff <= MW'(mag_a);
      mb_ff <= MW'(mag_b);
      n1_ff <= a_in[W-1] ^ b_in[W-1];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NCH; i++) begin
         for (int j = 0; j < NCH; j++) begin
            pp_ff[i][j] <= ma_ff[i*C +: C] * mb_ff[j*C +: C];
         end
      end
      n2_ff <= n1_ff;
   end

   always_comb begin
      for (int i = 0; i < NCH; i++) begin
         row_c[i] = '0;
         for (int j = 0; j < NCH; j++) begin
            row_c[i] = row_c[i] + (PW'(pp_ff[i][j]) << (C * j));
         end
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_c;
      n3_ff  <= n2_ff;
   end

   always_comb begin
      tot_c = '0;
      for (int i = 0; i < NCH; i++) begin
         tot_c = tot_c + (row_ff[i] << (C * i));
      end
   end

   always_ff @(posedge clock) begin
      tot_ff <= tot_c;
      n4_ff  <= n3_ff;
   end

   always_comb begin
      t_c = {1'b0, tot_ff};
      r_c = n4_ff ? -t_c : t_c;
   end

   always_ff @(posedge clock) begin
      p_ff <= r_c[2*W:0];
   end

   assign p_out = p_ff;
endmodule

// ===== hdl/veac_circle.sv =====
// ----------------------------------------------------------------------------
// veac_circle
// exact hit test of one edge against one circle, fully pipelined
// ----------------------------------------------------------------------------
module veac_circle import veac_pkg::*; (
   input  logic      clock,
   input  item_type  item,
   input  coord_type cx,
   input  coord_type cy,
   input  rsq_type   rsq,
   output hit_type   res
);
   typedef struct packed {
      logic li;
      logic ri;
      logic pneg;
      logic qpos;
      logic upper;
      logic full;
   } flag_type;

   // stage 1: offsets from the center
   diff_type      mlx1_ff, mly1_ff, mrx1_ff, mry1_ff, mx1_ff, my1_ff;
   diff_type      dx1_ff, dy1_ff;
   coord_type     a1_ff, b1_ff, c1_ff, cx1_ff, cy1_ff;
   edge_kind_type kind1_ff;
   logic          hl1_ff, hr1_ff, sel1_ff;

   always_ff @(posedge clock) begin
      mlx1_ff  <= ext_d(item.lx) - ext_d(cx);
      mly1_ff  <= ext_d(item.ly) - ext_d(cy);
      mrx1_ff  <= ext_d(item.rx) - ext_d(cx);
      mry1_ff  <= ext_d(item.ry) - ext_d(cy);
      mx1_ff   <= ext_d(item.sx) - ext_d(cx);
      my1_ff   <= ext_d(item.sy) - ext_d(cy);
      dx1_ff   <= item.dx;
      dy1_ff   <= item.dy;
      a1_ff    <= item.a;
      b1_ff    <= item.b;
      c1_ff    <= item.c;
      cx1_ff   <= cx;
      cy1_ff   <= cy;
      kind1_ff <= item.kind;
      hl1_ff   <= item.hl;
      hr1_ff   <= item.hr;
      sel1_ff  <= item.sel_l;
   end

   // stage 2: narrow products
   prod_type      lxx2_ff, lyy2_ff, rxx2_ff, ryy2_ff, dmx2_ff, dmy2_ff;
   prod_type      dxx2_ff, dyy2_ff, acx2_ff, bcy2_ff, aa2_ff, bb2_ff;
   coord_type     c2_ff;
   edge_kind_type kind2_ff;
   logic          hl2_ff, hr2_ff, sel2_ff;

   always_ff @(posedge clock) begin
      lxx2_ff  <= mlx1_ff * mlx1_ff;
      lyy2_ff  <= mly1_ff * mly1_ff;
      rxx2_ff  <= mrx1_ff * mrx1_ff;
      ryy2_ff  <= mry1_ff * mry1_ff;
      dmx2_ff  <= dx1_ff * mx1_ff;
      dmy2_ff  <= dy1_ff * my1_ff;
      dxx2_ff  <= dx1_ff * dx1_ff;
      dyy2_ff  <= dy1_ff * dy1_ff;
      acx2_ff  <= a1_ff * cx1_ff;
      bcy2_ff  <= b1_ff * cy1_ff;
      aa2_ff   <= a1_ff * a1_ff;
      bb2_ff   <= b1_ff * b1_ff;
      c2_ff    <= c1_ff;
      kind2_ff <= kind1_ff;
      hl2_ff   <= hl1_ff;
      hr2_ff   <= hr1_ff;
      sel2_ff  <= sel1_ff;
   end

   // stage 3: sums
   val_type       dl3_ff, dr3_ff, dd3_ff, ds3_ff, k3_ff, ab3_ff;
   edge_kind_type kind3_ff;
   logic          hl3_ff, hr3_ff, sel3_ff;

   always_ff @(posedge clock) begin
      dl3_ff   <= val_type'(lxx2_ff) + val_type'(lyy2_ff);
      dr3_ff   <= val_type'(rxx2_ff) + val_type'(ryy2_ff);
      dd3_ff   <= val_type'(dmx2_ff) + val_type'(dmy2_ff);
      ds3_ff   <= val_type'(dxx2_ff) + val_type'(dyy2_ff);
      k3_ff    <= (val_type'(c2_ff) <<< FRAC_BITS) - val_type'(acx2_ff)
                  - val_type'(bcy2_ff);
      ab3_ff   <= val_type'(aa2_ff) + val_type'(bb2_ff);
      kind3_ff <= kind2_ff;
      hl3_ff   <= hl2_ff;
      hr3_ff   <= hr2_ff;
      sel3_ff  <= sel2_ff;
   end

   // stage 4: inside tests and wide operands
   val_type  rsq_v, e_c, q_c;
   val_type  m1_ff, m2a_ff, m2b_ff, m3_ff;
   flag_type fl4_in, fl4_ff;
   logic     full3;

   always_comb begin
      rsq_v        = val_type'({1'b0, rsq});
      full3        = kind3_ff == KIND_FULL;
      e_c          = (sel3_ff ? dl3_ff : dr3_ff) - rsq_v;
      q_c          = -dd3_ff - ds3_ff;
      fl4_in.li    = hl3_ff && (dl3_ff < rsq_v);
      fl4_in.ri    = hr3_ff && (dr3_ff < rsq_v);
      fl4_in.pneg  = dd3_ff > 0;
      fl4_in.qpos  = q_c > 0;
      fl4_in.upper = kind3_ff == KIND_SEG;
      fl4_in.full  = full3;
   end

   always_ff @(posedge clock) begin
      m1_ff  <= full3 ? k3_ff : dd3_ff;
      m2a_ff <= full3 ? ab3_ff : ds3_ff;
      m2b_ff <= full3 ? rsq_v : e_c;
      m3_ff  <= q_c;
      fl4_ff <= fl4_in;
   end

   wprod_type p1, p2, p3;

   veac_wmul #(.W(VAL_W)) u_mul1 (.clock(clock), .a_in(m1_ff), .b_in(m1_ff), .p_out(p1));
   veac_wmul #(.W(VAL_W)) u_mul2 (.clock(clock), .a_in(m2a_ff), .b_in(m2b_ff), .p_out(p2));
   veac_wmul #(.W(VAL_W)) u_mul3 (.clock(clock), .a_in(m3_ff), .b_in(m3_ff), .p_out(p3));

   flag_type fl_ff [MUL_LAT];

   always_ff @(posedge clock) begin
      fl_ff[0] <= fl4_ff;
      for (int i = 1; i < MUL_LAT; i++) begin
         fl_ff[i] <= fl_ff[i-1];
      end
   end

   // discriminant
   disc_type disc_a_ff, pp_a_ff, qq_a_ff;
   flag_type fla_ff;

   always_ff @(posedge clock) begin
      disc_a_ff <= fl_ff[MUL_LAT-1].full ? disc_type'(p2) - disc_type'(p1)
                                         : disc_type'(p1) - disc_type'(p2);
      pp_a_ff   <= disc_type'(p1);
      qq_a_ff   <= disc_type'(p3);
      fla_ff    <= fl_ff[MUL_LAT-1];
   end

   // decision
   logic    dpos, ltp, ltq, line_ok;
   hit_type res_ff;

   always_comb begin
      dpos    = disc_a_ff > 0;
      ltp     = pp_a_ff < disc_a_ff;
      ltq     = disc_a_ff < qq_a_ff;
      line_ok = fla_ff.full ? dpos
              : dpos && !fla_ff.pneg && !ltp && !(fla_ff.upper && fla_ff.qpos && ltq);
   end

   always_ff @(posedge clock) begin
      res_ff.hit  <= fla_ff.li || fla_ff.ri || line_ok;
      res_ff.l_in <= fla_ff.li;
      res_ff.r_in <= fla_ff.ri;
   end

   assign res = res_ff;
endmodule

// ===== hdl/veac_back.sv =====
// ----------------------------------------------------------------------------
// veac_back
// issues queued edges into the circle units and buffers the results
// ----------------------------------------------------------------------------
module veac_back import veac_pkg::*; #(
   parameter int NUM_CIRCLES = DEFAULT_NUM_CIRCLES
) (
   input  logic       clock,
   input  logic       reset,
   input  item_type   q_item,
   input  logic       q_valid,
   output logic       q_ready,
   input  cfg_type    cfg,
   veac_rsp_if.source rsp
);
   localparam int RW = $clog2(OQ_DEPTH) + 1;

   logic [RW-1:0] resv_ff, resv_in;
   logic          issue, push, pop, of_in_ready, of_valid;
   logic [CIRCLE_LAT-1:0] v_ff;
   logic [1:0]    sf_ff [CIRCLE_LAT];
   coord_type     cx_sel [MAX_CIRCLES];
   coord_type     cy_sel [MAX_CIRCLES];
   hit_type       hits [MAX_CIRCLES];
   result_type    res_c, of_data;

   // reserve a result slot for every item in flight
   assign q_ready = resv_ff < RW'(OQ_DEPTH);
   assign issue   = q_valid && q_ready;
   assign push    = v_ff[CIRCLE_LAT-1];
   assign pop     = rsp.valid && rsp.ready;
   assign resv_in = resv_ff + RW'(issue) - RW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         resv_ff <= '0;
         v_ff    <= '0;
      end else begin
         resv_ff <= resv_in;
         v_ff    <= {v_ff[CIRCLE_LAT-2:0], issue};
      end
   end

   always_ff @(posedge clock) begin
      sf_ff[0] <= {q_item.lself, q_item.rself};
      for (int i = 1; i < CIRCLE_LAT; i++) begin
         sf_ff[i] <= sf_ff[i-1];
      end
   end

   assign cx_sel[0] = cfg.own_x;
   assign cy_sel[0] = cfg.own_y;
   assign cx_sel[1] = cfg.old_x;
   assign cy_sel[1] = cfg.old_y;
   assign cx_sel[2] = cfg.new_x;
   assign cy_sel[2] = cfg.new_y;

   for (genvar g = 0; g < MAX_CIRCLES; g++) begin : g_circ
      if (g < NUM_CIRCLES) begin : g_on
         veac_circle u_circle (
            .clock (clock),
            .item  (q_item),
            .cx    (cx_sel[g]),
            .cy    (cy_sel[g]),
            .rsq   (cfg.rsq),
            .res   (hits[g])
         );
      end else begin : g_off
         assign hits[g] = '0;
      end
   end

   always_comb begin
      res_c.inner_own       = hits[0].hit;
      res_c.inner_old       = hits[1].hit && cfg.disc_on;
      res_c.inner_new       = hits[2].hit && cfg.disc_on;
      res_c.outer_edge      = !(hits[0].l_in && hits[0].r_in);
      res_c.left_enclosing  = sf_ff[CIRCLE_LAT-1][0];
      res_c.right_enclosing = sf_ff[CIRCLE_LAT-1][1];
   end

   veac_fifo #(.W(RESULT_W), .DEPTH(OQ_DEPTH)) u_out_q (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push),
      .in_ready  (of_in_ready),
      .in_data   (res_c),
      .out_valid (of_valid),
      .out_ready (rsp.ready),
      .out_data  (of_data)
   );

   assign rsp.valid           = of_valid;
   assign rsp.inner_own       = of_data.inner_own;
   assign rsp.inner_old       = of_data.inner_old;
   assign rsp.inner_new       = of_data.inner_new;
   assign rsp.outer_edge      = of_data.outer_edge;
   assign rsp.left_enclosing  = of_data.left_enclosing;
   assign rsp.right_enclosing = of_data.right_enclosing;

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> of_in_ready)
      else $error("result arrived with no free slot");

   a_resv_bound: assert property (@(posedge clock) disable iff (reset)
      resv_ff <= RW'(OQ_DEPTH))
      else $error("reservation count beyond result buffer");

   a_rsp_backed: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> resv_ff != '0)
      else $error("result shown without a reserved slot");
endmodule

// ===== hdl/voronoi_edge_aoi_classifier.sv =====
// ----------------------------------------------------------------------------
// voronoi_edge_aoi_classifier
// classifies voronoi edges against the own, old and new interest circles
//
// req_ch takes one edge per item (endpoints, line a*x+b*y=c, self flags);
// rsp_ch returns one result item per edge in the same order.
// csr_we/csr_index/csr_wdata write the centers and the squared radius;
// write them only while no edge is in flight.
// from the accepting edge to the earliest result an edge passes one
// front register, the queue, 11 stages of circle math (one of them
// narrow multiplies plus a 5 stage wide multiplier) and the result
// buffer. one item enters and one leaves per cycle at full rate.
// a stalled receiver fills the 16 entry result buffer; issue from the
// 4 entry edge queue stops once every result slot is reserved, then
// the queue and front register fill and req_ch.ready drops.
// reset clears the configuration registers to zero and empties queue and buffer.
// ----------------------------------------------------------------------------
module voronoi_edge_aoi_classifier import veac_pkg::*; #(
   parameter int NUM_CIRCLES = DEFAULT_NUM_CIRCLES
) (
   input  logic                       clock,
   input  logic                       reset,
   veac_req_if.sink                   req_ch,
   veac_rsp_if.source                 rsp_ch,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);
   coord_type own_x_ff, own_y_ff, old_x_ff, old_y_ff, new_x_ff, new_y_ff;
   rsq_type   rsq_ff;
   cfg_type   cfg;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_x_ff <= '0;
         own_y_ff <= '0;
         old_x_ff <= '0;
         old_y_ff <= '0;
         new_x_ff <= '0;
         new_y_ff <= '0;
         rsq_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_OWN_X: own_x_ff <= csr_wdata[COORD_WIDTH-1:0];
            REG_OWN_Y: own_y_ff <= csr_wdata[COORD_WIDTH-1:0];
            REG_OLD_X: old_x_ff <= csr_wdata[COORD_WIDTH-1:0];
            REG_OLD_Y: old_y_ff <= csr_wdata[COORD_WIDTH-1:0];
            REG_NEW_X: new_x_ff <= csr_wdata[COORD_WIDTH-1:0];
            REG_NEW_Y: new_y_ff <= csr_wdata[COORD_WIDTH-1:0];
            REG_RSQ:   rsq_ff   <= csr_wdata[RSQ_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.own_x   = own_x_ff;
      cfg.own_y   = own_y_ff;
      cfg.old_x   = old_x_ff;
      cfg.old_y   = old_y_ff;
      cfg.new_x   = new_x_ff;
      cfg.new_y   = new_y_ff;
      cfg.rsq     = rsq_ff;
      cfg.disc_on = (old_x_ff != new_x_ff) || (old_y_ff != new_y_ff);
   end

   item_type         fe_item;
   logic             fe_valid, fe_ready;
   logic [ITEM_W-1:0] q_data;
   logic             q_valid, q_ready;

   veac_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .item       (fe_item),
      .item_valid (fe_valid),
      .item_ready (fe_ready)
   );

   veac_fifo #(.W(ITEM_W), .DEPTH(QUEUE_DEPTH)) u_edge_q (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_ready  (fe_ready),
      .in_data   (fe_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   veac_back #(.NUM_CIRCLES(NUM_CIRCLES)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_item  (item_type'(q_data)),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .cfg     (cfg),
      .rsp     (rsp_ch)
   );
endmodule

// ===== sim/voronoi_edge_aoi_classifier_chk.sv =====
// ----------------------------------------------------------------------------
// voronoi_edge_aoi_classifier_chk
// result checker for the voronoi edge classifier
//
// Watches the configuration writes and both channels. For every accepted
// edge item it works out the expected flags with exact wide integer math
// and queues them. Each accepted result item is compared field by field
// with the oldest queued expectation. The failure count and the number of
// expectations still waiting go to the testbench top.
// ----------------------------------------------------------------------------
module voronoi_edge_aoi_classifier_chk import veac_pkg::*; #(
   parameter int NUM_CIRCLES = DEFAULT_NUM_CIRCLES
) (
   input  logic                       clock,
   input  logic                       reset,
   veac_req_if                        req_ch,
   veac_rsp_if                        rsp_ch,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                         errors,
   output int                         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   typedef logic signed [191:0] wide_type;

   coord_type  ctr_x [3];
   coord_type  ctr_y [3];
   rsq_type    rsq_reg;
   result_type flags_q [$];

   function automatic wide_type wd(longint v);
      return wide_type'(v);
   endfunction

   function automatic wide_type radius_sq();
      wide_type r;
      r = '0;
      r[RSQ_WIDTH-1:0] = rsq_reg;
      return r;
   endfunction

   function automatic bit point_inside(longint px, longint py, longint cx, longint cy);
      wide_type ddx;
      wide_type ddy;
      ddx = wd(px - cx);
      ddy = wd(py - cy);
      return (ddx * ddx + ddy * ddy) < radius_sq();
   endfunction

   // segment (bounded) or ray from (sx, sy) along (dx, dy)
   function automatic bit path_hits(longint sx, longint sy, longint dx, longint dy,
                                    longint cx, longint cy, bit bounded);
      wide_type mx, my, wdx, wdy, dd, ds, ms, disc, p, q;
      mx   = wd(sx - cx);
      my   = wd(sy - cy);
      wdx  = wd(dx);
      wdy  = wd(dy);
      dd   = wdx * mx + wdy * my;
      ds   = wdx * wdx + wdy * wdy;
      ms   = mx * mx + my * my;
      disc = dd * dd - ds * (ms - radius_sq());
      p    = -dd;
      if (disc <= 0) return 1'b0;
      if (p < 0 || p * p < disc) return 1'b0;
      if (bounded) begin
         q = p - ds;
         if (q > 0 && disc < q * q) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic bit line_hits(longint a, longint b, longint c, longint cx, longint cy);
      wide_type k, lhs;
      k   = wd(c) * wd(longint'(1) << FRAC_BITS) - wd(a) * wd(cx) - wd(b) * wd(cy);
      lhs = (wd(a) * wd(a) + wd(b) * wd(b)) * radius_sq();
      return (lhs - k * k) > 0;
   endfunction

   function automatic result_type classify_edge();
      result_type res;
      longint lx, ly, rx, ry, a, b, c, dx, dy, cx, cy;
      bit hl, hr, li, ri, lin_own, rin_own, discovery;
      bit hit [3];
      int ntest;
      lx = longint'(req_ch.left_x);
      ly = longint'(req_ch.left_y);
      rx = longint'(req_ch.right_x);
      ry = longint'(req_ch.right_y);
      a  = longint'(req_ch.coef_a);
      b  = longint'(req_ch.coef_b);
      c  = longint'(req_ch.coef_c);
      hl = req_ch.has_left;
      hr = req_ch.has_right;
      lin_own = 1'b0;
      rin_own = 1'b0;
      hit = '{1'b0, 1'b0, 1'b0};
      discovery = (ctr_x[1] != ctr_x[2]) || (ctr_y[1] != ctr_y[2]);
      ntest = discovery ? 3 : 1;
      if (ntest > NUM_CIRCLES) ntest = NUM_CIRCLES;
      for (int i = 0; i < ntest; i++) begin
         cx = longint'(ctr_x[i]);
         cy = longint'(ctr_y[i]);
         li = hl && point_inside(lx, ly, cx, cy);
         ri = hr && point_inside(rx, ry, cx, cy);
         if (i == 0) begin
            lin_own = li;
            rin_own = ri;
         end
         if (li || ri) begin
            hit[i] = 1'b1;
         end else if (hl && hr) begin
            hit[i] = path_hits(lx, ly, rx - lx, ry - ly, cx, cy, 1'b1);
         end else if (hl || hr) begin
            dx = b;
            dy = -a;
            // rays from a left end point toward +x, from a right end toward -x
            if ((hl && dx < 0) || (!hl && dx >= 0)) begin
               dx = -dx;
               dy = -dy;
            end
            hit[i] = hl ? path_hits(lx, ly, dx, dy, cx, cy, 1'b0)
                        : path_hits(rx, ry, dx, dy, cx, cy, 1'b0);
         end else begin
            hit[i] = line_hits(a, b, c, cx, cy);
         end
      end
      res.inner_own       = hit[0];
      res.inner_old       = hit[1];
      res.inner_new       = hit[2];
      res.outer_edge      = !lin_own || !rin_own;
      res.left_enclosing  = req_ch.right_is_self;
      res.right_enclosing = req_ch.left_is_self;
      return res;
   endfunction

   always @(posedge clock) begin
      result_type want, got;
      if (reset) begin
         ctr_x   = '{default: '0};
         ctr_y   = '{default: '0};
         rsq_reg = '0;
         errors  = 0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               REG_OWN_X: ctr_x[0] = csr_wdata[COORD_WIDTH-1:0];
               REG_OWN_Y: ctr_y[0] = csr_wdata[COORD_WIDTH-1:0];
               REG_OLD_X: ctr_x[1] = csr_wdata[COORD_WIDTH-1:0];
               REG_OLD_Y: ctr_y[1] = csr_wdata[COORD_WIDTH-1:0];
               REG_NEW_X: ctr_x[2] = csr_wdata[COORD_WIDTH-1:0];
               REG_NEW_Y: ctr_y[2] = csr_wdata[COORD_WIDTH-1:0];
               REG_RSQ:   rsq_reg  = csr_wdata;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) flags_q.insert(flags_q.size(), classify_edge());
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.inner_own       = rsp_ch.inner_own;
            got.inner_old       = rsp_ch.inner_old;
            got.inner_new       = rsp_ch.inner_new;
            got.outer_edge      = rsp_ch.outer_edge;
            got.left_enclosing  = rsp_ch.left_enclosing;
            got.right_enclosing = rsp_ch.right_enclosing;
            if (flags_q.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("%0t: result item with nothing expected: %b", $realtime, got);
            end else begin
               want = flags_q.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display("%0t: flags own/old/new/outer/lenc/renc expected %b got %b",
                              $realtime, want, got);
               end
            end
         end
      end
      pending = flags_q.size();
   end

endmodule

// ===== sim/voronoi_edge_aoi_classifier_tb.sv =====
// ----------------------------------------------------------------------------
// voronoi_edge_aoi_classifier_tb
// stimulus and verdict for the voronoi edge classifier
//
// Runs several configuration phases (reset values, extreme centers and
// radii, random ones, discovery on and off). Each phase starts once all
// results are in. A directed set of edges covers extremes, boundary
// points and degenerate lines, then random segments, rays and lines
// are aimed near the circles. The sender idles in bursts, the receiver
// stalls at varying rates. Checking is done by the checker module.
// ----------------------------------------------------------------------------
module voronoi_edge_aoi_classifier_tb;
   import veac_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 30;
   localparam int NUM_PHASES     = 6;
   localparam int PHASE_ITEMS    = 330;
   localparam coord_type C_MIN   = 32'sh8000_0000;
   localparam coord_type C_MAX   = 32'sh7fff_ffff;
   localparam coord_type ONE     = 32'sh0001_0000;

   logic                       clock;
   logic                       reset;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;
   int                         errors;
   int                         pending;
   int                         stall_cycles;
   int                         ready_pct = 100;
   int                         burst_left;
   bit                         gaps_on;
   coord_type                  ctr_x [3];
   coord_type                  ctr_y [3];

   veac_req_if req_ch ();
   veac_rsp_if rsp_ch ();

   voronoi_edge_aoi_classifier i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   voronoi_edge_aoi_classifier_chk i_chk (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .errors    (errors),
      .pending   (pending)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(negedge clock) rsp_ch.ready <= ($urandom_range(0, 99) < ready_pct);

   always begin
      repeat (300) @(posedge clock);
      case ($urandom_range(0, 4))
         0, 1: ready_pct = 100;
         2: ready_pct = 70;
         3: ready_pct = 35;
         default: ready_pct = 8;
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_edge(coord_type lx, coord_type ly, coord_type rx, coord_type ry,
                            bit hl, bit hr, coord_type a, coord_type b, coord_type c,
                            bit ls, bit rs);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if (gaps_on) begin
            repeat ($urandom_range(1, 12)) begin
               @(negedge clock);
               req_ch.valid = 1'b0;
            end
         end
      end
      burst_left--;
      @(negedge clock);
      req_ch.valid         = 1'b1;
      req_ch.left_x        = lx;
      req_ch.left_y        = ly;
      req_ch.right_x       = rx;
      req_ch.right_y       = ry;
      req_ch.has_left      = hl;
      req_ch.has_right     = hr;
      req_ch.coef_a        = a;
      req_ch.coef_b        = b;
      req_ch.coef_c        = c;
      req_ch.left_is_self  = ls;
      req_ch.right_is_self = rs;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_regs(coord_type ox, coord_type oy, coord_type px, coord_type py,
                             coord_type nx, coord_type ny, rsq_type rsq);
      logic [CSR_DATA_WIDTH-1:0] vals [7];
      vals = '{CSR_DATA_WIDTH'(ox), CSR_DATA_WIDTH'(oy), CSR_DATA_WIDTH'(px),
               CSR_DATA_WIDTH'(py), CSR_DATA_WIDTH'(nx), CSR_DATA_WIDTH'(ny), rsq};
      // sign bits above the coordinate width are don't care
      for (int i = 0; i < 6; i++)
         vals[i][CSR_DATA_WIDTH-1:COORD_WIDTH] = (CSR_DATA_WIDTH-COORD_WIDTH)'($urandom);
      ctr_x = '{ox, px, nx};
      ctr_y = '{oy, py, ny};
      for (int i = 0; i < 7; i++) begin
         @(negedge clock);
         csr_we    = 1'b1;
         csr_index = csr_index_type'(i);
         csr_wdata = vals[i];
      end
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic coord_type pick_center(bit extreme);
      if (extreme) begin
         case ($urandom_range(0, 2))
            0: return C_MIN;
            1: return C_MAX;
            default: return '0;
         endcase
      end
      return coord_type'($signed($urandom) >>> $urandom_range(4, 16));
   endfunction

   function automatic rsq_type pick_rsq();
      logic [63:0] r;
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return rsq_type'({$urandom, $urandom});
         default: begin
            r = 64'($urandom >> $urandom_range(8, 24));
            return rsq_type'(r * r);
         end
      endcase
   endfunction

   function automatic coord_type near(coord_type v);
      return v + coord_type'($signed($urandom) >>> $urandom_range(4, 28));
   endfunction

   function automatic coord_type pick_coef();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return coord_type'($urandom);
         default: return coord_type'($signed($urandom) >>> $urandom_range(6, 24));
      endcase
   endfunction

   task automatic random_edge();
      coord_type lx, ly, rx, ry, a, b, c, cx, cy;
      longint t;
      int k;
      bit hl, hr;
      k  = $urandom_range(0, 2);
      cx = ctr_x[k];
      cy = ctr_y[k];
      if ($urandom_range(0, 9) == 0) begin
         send_edge($urandom, $urandom, $urandom, $urandom, 1'($urandom), 1'($urandom),
                   $urandom, $urandom, $urandom, 1'($urandom), 1'($urandom));
      end else begin
         lx = near(cx);
         ly = near(cy);
         rx = near(cx);
         ry = near(cy);
         a  = pick_coef();
         b  = pick_coef();
         t  = ((longint'(a) * longint'(cx)) >>> FRAC_BITS) +
              ((longint'(b) * longint'(cy)) >>> FRAC_BITS);
         c  = coord_type'(t) + coord_type'($signed($urandom) >>> $urandom_range(4, 30));
         hl = 1'($urandom_range(0, 1));
         hr = 1'($urandom_range(0, 1));
         send_edge(lx, ly, rx, ry, hl, hr, a, b, c, 1'($urandom), 1'($urandom));
      end
   endtask

   task automatic directed_edges();
      // own circle at the origin with radius 1.0, old at (2,0), new at (0,3)
      send_edge(ONE, '0, ONE, '0, 1, 1, '0, '0, '0, 0, 0);
      send_edge(ONE - 1, '0, C_MAX, C_MAX, 1, 1, '0, '0, '0, 1, 0);
      send_edge(C_MIN, C_MIN, C_MAX, C_MAX, 1, 1, '0, '0, '0, 0, 1);
      send_edge(C_MAX, C_MIN, C_MIN, C_MAX, 1, 1, C_MIN, C_MAX, C_MIN, 1, 1);
      send_edge(-2 * ONE, ONE / 2, 5 * ONE, ONE / 2, 1, 1, '0, '0, '0, 0, 0);
      send_edge(-2 * ONE, ONE, 5 * ONE, ONE, 1, 1, '0, '0, '0, 0, 0);
      send_edge(3 * ONE, 3 * ONE, 3 * ONE, 3 * ONE, 1, 1, '0, '0, '0, 0, 0);
      send_edge(-4 * ONE, '0, '0, '0, 1, 0, '0, ONE, '0, 0, 0);
      send_edge('0, '0, 4 * ONE, '0, 0, 1, '0, ONE, '0, 0, 0);
      send_edge(-4 * ONE, '0, 4 * ONE, '0, 1, 0, '0, -ONE, '0, 1, 0);
      send_edge(-4 * ONE, '0, 4 * ONE, '0, 0, 1, '0, -ONE, '0, 0, 1);
      send_edge(4 * ONE, 4 * ONE, '0, '0, 1, 0, '0, '0, '0, 0, 0);
      send_edge('0, '0, '0, '0, 0, 0, '0, '0, '0, 0, 0);
      send_edge('0, '0, '0, '0, 0, 0, '0, '0, ONE, 0, 0);
      send_edge('0, '0, '0, '0, 0, 0, ONE, '0, ONE / 2, 0, 0);
      send_edge('0, '0, '0, '0, 0, 0, ONE, '0, ONE, 0, 0);
      send_edge('0, '0, '0, '0, 0, 0, '0, ONE, 3 * ONE, 1, 1);
      send_edge('0, '0, '0, '0, 0, 0, C_MAX, C_MIN, C_MAX, 0, 0);
      send_edge('0, '0, '0, '0, 0, 0, C_MIN, C_MIN, C_MIN, 0, 0);
      send_edge(C_MIN, '0, '0, C_MAX, 1, 0, C_MIN, C_MIN, '0, 0, 0);
      send_edge(C_MIN, '0, C_MAX, '0, 0, 1, C_MAX, C_MAX, '0, 0, 0);
   endtask

   initial begin
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      req_ch.valid         = 1'b0;
      req_ch.left_x        = '0;
      req_ch.left_y        = '0;
      req_ch.right_x       = '0;
      req_ch.right_y       = '0;
      req_ch.has_left      = 1'b0;
      req_ch.has_right     = 1'b0;
      req_ch.coef_a        = '0;
      req_ch.coef_b        = '0;
      req_ch.coef_c        = '0;
      req_ch.left_is_self  = 1'b0;
      req_ch.right_is_self = 1'b0;
      ctr_x                = '{default: '0};
      ctr_y                = '{default: '0};
      burst_left           = 0;
      gaps_on              = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // registers at reset values: zero radius, discovery off
      repeat (40) random_edge();
      drain();
      write_regs('0, '0, 2 * ONE, '0, '0, 3 * ONE, rsq_type'(64'h1_0000_0000));
      directed_edges();
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         drain();
         gaps_on = (ph % 3) != 0;
         case (ph)
            0: write_regs(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, '1);
            1: write_regs(C_MAX, C_MIN, '0, '0, '0, '0, '0);
            2: write_regs(pick_center(0), pick_center(0), ONE, ONE, ONE, ONE, pick_rsq());
            default: write_regs(pick_center($urandom_range(0, 3) == 0), pick_center(0),
                                pick_center($urandom_range(0, 3) == 0), pick_center(0),
                                pick_center(0), pick_center($urandom_range(0, 3) == 0),
                                pick_rsq());
         endcase
         repeat (PHASE_ITEMS) random_edge();
      end
      drain();
      if (errors == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
